// File: design/trp_pkg.sv
// ----------------------------------------------------------------------------
// trp_pkg
// Types and constants shared by the TLV record parser modules.
// ----------------------------------------------------------------------------
package trp_pkg;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int TDATA_W  = 104;

    localparam logic [2:0] REG_TAG_KIND     = 3'd0;
    localparam logic [2:0] REG_TAG_SEQUENCE = 3'd1;
    localparam logic [2:0] REG_TAG_FLAGS    = 3'd2;
    localparam logic [2:0] REG_TAG_BODY     = 3'd3;
    localparam logic [2:0] REG_BODY_LIMIT   = 3'd4;

    localparam logic [7:0]  TAG_KIND_RST     = 8'd1;
    localparam logic [7:0]  TAG_SEQUENCE_RST = 8'd2;
    localparam logic [7:0]  TAG_FLAGS_RST    = 8'd3;
    localparam logic [7:0]  TAG_BODY_RST     = 8'd4;
    localparam logic [15:0] BODY_LIMIT_RST   = 16'd256;

    localparam logic [15:0] LEN_KIND     = 16'd1;
    localparam logic [15:0] LEN_SEQUENCE = 16'd4;
    localparam logic [15:0] LEN_FLAGS    = 16'd2;

    localparam logic [2:0] CLS_KIND  = 3'd0;
    localparam logic [2:0] CLS_SEQ   = 3'd1;
    localparam logic [2:0] CLS_FLAGS = 3'd2;
    localparam logic [2:0] CLS_BODY  = 3'd3;
    localparam logic [2:0] CLS_NONE  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_LEN   = 2'd2;

    localparam logic [1:0] HDR_TAG    = 2'd0;
    localparam logic [1:0] HDR_LEN_HI = 2'd1;
    localparam logic [1:0] HDR_LEN_LO = 2'd2;
    localparam logic [1:0] HDR_VALUE  = 2'd3;

    localparam logic RES_BODY    = 1'b0;
    localparam logic RES_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0]  tag_kind;
        logic [7:0]  tag_sequence;
        logic [7:0]  tag_flags;
        logic [7:0]  tag_body;
        logic [15:0] body_limit;
    } cfg_t;

    typedef struct packed {
        logic        body_valid;
        logic [7:0]  body_byte;
        logic [15:0] body_offset;
        logic        sum_valid;
        logic [1:0]  status;
        logic [3:0]  marks;
        logic [7:0]  kind_value;
        logic [31:0] sequence_number;
        logic [15:0] flag_word;
        logic [15:0] body_length;
    } entry_t;

    typedef struct packed {
        logic [1:0]  pad;
        logic [15:0] body_length;
        logic        body_seen;
        logic [15:0] flag_word;
        logic        flags_seen;
        logic [31:0] sequence_number;
        logic        seq_seen;
        logic [7:0]  kind_value;
        logic        kind_seen;
        logic [1:0]  status;
        logic [15:0] body_offset;
        logic [7:0]  body_byte;
    } result_t;

    function automatic logic [2:0] classify(input logic [7:0] tag, input cfg_t cfg);
        logic [2:0] cls;
        if (tag == cfg.tag_kind) begin
            cls = CLS_KIND;
        end else if (tag == cfg.tag_sequence) begin
            cls = CLS_SEQ;
        end else if (tag == cfg.tag_flags) begin
            cls = CLS_FLAGS;
        end else if (tag == cfg.tag_body) begin
            cls = CLS_BODY;
        end else begin
            cls = CLS_NONE;
        end
        return cls;
    endfunction

endpackage

// File: design/tlv_record_parser.sv
// ----------------------------------------------------------------------------
// tlv_record_parser
// Byte-serial tag-length-value message parser with APB configuration.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle on the s_ stream while the request queue
// has room, and emits each body byte of a valid body record as it arrives,
// plus a summary result on the item that carries tlast. The parser state
// advances once per accepted byte; a request queue of QUEUE_DEPTH entries
// and a registered output stage sit behind it. An item that yields both a
// body byte and a summary gives the body result first, then the summary;
// every other item gives at most one result.
module tlv_record_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trp_pkg::ADDR_W-1:0]    paddr,
    input  logic [trp_pkg::DATA_W-1:0]    pwdata,
    output logic [trp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] data_byte
    input  logic                          s_tlast,  // last_byte
    input  logic                          s_tuser,  // no_data
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] body_byte, [23:8] body_offset, [25:24] status, [26] kind_seen,
    // [34:27] kind_value, [35] seq_seen, [67:36] sequence_number,
    // [68] flags_seen, [84:69] flag_word, [85] body_seen, [101:86] body_length
    output logic [trp_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tuser   // result_kind
);
    import trp_pkg::*;

    cfg_t   cfg;
    logic   push_valid, push_ready;
    entry_t push_entry;
    logic   pop_valid, pop_ready;
    entry_t pop_entry;

    trp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    trp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    trp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    trp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: design/trp_regs.sv
// ----------------------------------------------------------------------------
// trp_regs
// APB register file holding the tag codes and the body length limit.
// ----------------------------------------------------------------------------
module trp_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [trp_pkg::ADDR_W-1:0]   paddr,
    input  logic [trp_pkg::DATA_W-1:0]   pwdata,
    output logic [trp_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output trp_pkg::cfg_t                cfg
);
    import trp_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tag_kind     <= TAG_KIND_RST;
            cfg_reg.tag_sequence <= TAG_SEQUENCE_RST;
            cfg_reg.tag_flags    <= TAG_FLAGS_RST;
            cfg_reg.tag_body     <= TAG_BODY_RST;
            cfg_reg.body_limit   <= BODY_LIMIT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TAG_KIND:     cfg_reg.tag_kind     <= pwdata[7:0];
                REG_TAG_SEQUENCE: cfg_reg.tag_sequence <= pwdata[7:0];
                REG_TAG_FLAGS:    cfg_reg.tag_flags    <= pwdata[7:0];
                REG_TAG_BODY:     cfg_reg.tag_body     <= pwdata[7:0];
                REG_BODY_LIMIT:   cfg_reg.body_limit   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TAG_KIND:     prdata = DATA_W'(cfg_reg.tag_kind);
            REG_TAG_SEQUENCE: prdata = DATA_W'(cfg_reg.tag_sequence);
            REG_TAG_FLAGS:    prdata = DATA_W'(cfg_reg.tag_flags);
            REG_TAG_BODY:     prdata = DATA_W'(cfg_reg.tag_body);
            REG_BODY_LIMIT:   prdata = DATA_W'(cfg_reg.body_limit);
            default:          prdata = '0;
        endcase
    end

endmodule

// File: design/trp_front.sv
// ----------------------------------------------------------------------------
// trp_front
// Byte parser: tracks the record header and value, keeps the per-message
// stores and queues one request for each item with a body byte or a summary.
// ----------------------------------------------------------------------------
module trp_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  trp_pkg::cfg_t    cfg,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,     // [7:0] data_byte
    input  logic             s_tlast,     // last_byte
    input  logic             s_tuser,     // no_data
    output logic             push_valid,
    input  logic             push_ready,
    output trp_pkg::entry_t  push_entry
);
    import trp_pkg::*;

    logic [1:0]  hc_reg,    hc_next;
    logic [7:0]  tag_reg,   tag_next;
    logic [15:0] len_reg,   len_next;
    logic [15:0] vc_reg,    vc_next;
    logic [31:0] acc_reg,   acc_next;
    logic        pend_reg,  pend_next;
    logic [1:0]  ferr_reg,  ferr_next;
    logic [3:0]  marks_reg, marks_next;
    logic [7:0]  kind_reg,  kind_next;
    logic [31:0] seq_reg,   seq_next;
    logic [15:0] flags_reg, flags_next;
    logic [15:0] blen_reg,  blen_next;

    logic       accept;
    logic       fin;
    logic       len_bad;
    logic [2:0] cls_cur;
    logic       emit_body;
    entry_t     entry;

    assign s_tready   = push_ready;
    assign accept     = s_tvalid && push_ready;
    assign cls_cur    = classify(tag_reg, cfg);
    assign push_entry = entry;
    assign push_valid = s_tvalid && (emit_body || s_tlast);

    always_comb begin
        case (cls_cur)
            CLS_KIND:  len_bad = ({len_reg[15:8], s_tdata} != LEN_KIND);
            CLS_SEQ:   len_bad = ({len_reg[15:8], s_tdata} != LEN_SEQUENCE);
            CLS_FLAGS: len_bad = ({len_reg[15:8], s_tdata} != LEN_FLAGS);
            CLS_BODY:  len_bad = ({len_reg[15:8], s_tdata} > cfg.body_limit);
            default:   len_bad = 1'b1;
        endcase
    end

    always_comb begin
        hc_next    = hc_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        vc_next    = vc_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        ferr_next  = ferr_reg;
        marks_next = marks_reg;
        kind_next  = kind_reg;
        seq_next   = seq_reg;
        flags_next = flags_reg;
        blen_next  = blen_reg;
        fin        = 1'b0;
        emit_body  = 1'b0;

        if (!s_tuser && ferr_reg == ST_OK) begin
            case (hc_reg)
                HDR_TAG: begin
                    tag_next = s_tdata;
                    hc_next  = HDR_LEN_HI;
                end
                HDR_LEN_HI: begin
                    len_next = {s_tdata, 8'h00};
                    hc_next  = HDR_LEN_LO;
                end
                HDR_LEN_LO: begin
                    len_next  = {len_reg[15:8], s_tdata};
                    vc_next   = '0;
                    acc_next  = '0;
                    pend_next = len_bad;
                    hc_next   = HDR_VALUE;
                    fin       = (len_next == 16'd0);
                end
                default: begin
                    emit_body = !pend_reg && (cls_cur == CLS_BODY);
                    acc_next  = {acc_reg[23:0], s_tdata};
                    vc_next   = vc_reg + 16'd1;
                    fin       = (vc_next == len_reg);
                end
            endcase
        end

        if (fin) begin
            if (pend_next) begin
                ferr_next = ST_LEN;
            end else begin
                case (cls_cur)
                    CLS_KIND: begin
                        kind_next     = acc_next[7:0];
                        marks_next[0] = 1'b1;
                    end
                    CLS_SEQ: begin
                        seq_next      = acc_next;
                        marks_next[1] = 1'b1;
                    end
                    CLS_FLAGS: begin
                        flags_next    = acc_next[15:0];
                        marks_next[2] = 1'b1;
                    end
                    CLS_BODY: begin
                        blen_next     = len_next;
                        marks_next[3] = 1'b1;
                    end
                    default: ferr_next = ST_LEN;
                endcase
            end
            hc_next   = HDR_TAG;
            pend_next = 1'b0;
        end

        entry                 = '0;
        entry.body_valid      = emit_body;
        entry.body_byte       = emit_body ? s_tdata : 8'h00;
        entry.body_offset     = emit_body ? vc_reg : 16'h0000;
        entry.sum_valid       = s_tlast;
        entry.status          = (ferr_next != ST_OK) ? ferr_next :
                                ((hc_next == HDR_VALUE) ? ST_TRUNC : ST_OK);
        entry.marks           = marks_next;
        entry.kind_value      = kind_next;
        entry.sequence_number = seq_next;
        entry.flag_word       = flags_next;
        entry.body_length     = blen_next;

        if (s_tlast) begin
            hc_next    = HDR_TAG;
            tag_next   = '0;
            len_next   = '0;
            vc_next    = '0;
            acc_next   = '0;
            pend_next  = 1'b0;
            ferr_next  = ST_OK;
            marks_next = '0;
            kind_next  = '0;
            seq_next   = '0;
            flags_next = '0;
            blen_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hc_reg    <= HDR_TAG;
            tag_reg   <= '0;
            len_reg   <= '0;
            vc_reg    <= '0;
            acc_reg   <= '0;
            pend_reg  <= 1'b0;
            ferr_reg  <= ST_OK;
            marks_reg <= '0;
            kind_reg  <= '0;
            seq_reg   <= '0;
            flags_reg <= '0;
            blen_reg  <= '0;
        end else if (accept) begin
            hc_reg    <= hc_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            vc_reg    <= vc_next;
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
            ferr_reg  <= ferr_next;
            marks_reg <= marks_next;
            kind_reg  <= kind_next;
            seq_reg   <= seq_next;
            flags_reg <= flags_next;
            blen_reg  <= blen_next;
        end
    end

endmodule

// File: design/trp_queue.sv
// ----------------------------------------------------------------------------
// trp_queue
// Small FIFO of parser requests between the front and the back.
// ----------------------------------------------------------------------------
module trp_queue #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  trp_pkg::entry_t  push_entry,
    output logic             pop_valid,
    input  logic             pop_ready,
    output trp_pkg::entry_t  pop_entry
);
    import trp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_entry  = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: design/trp_back.sv
// ----------------------------------------------------------------------------
// trp_back
// Result stage: turns each request into a body-byte result, a summary result
// or both (body first) and holds them in the output register.
// ----------------------------------------------------------------------------
module trp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  trp_pkg::entry_t               pop_entry,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [trp_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tuser
);
    import trp_pkg::*;

    logic    tvalid_reg, tvalid_next;
    logic    tuser_reg,  tuser_next;
    result_t res_reg,    res_next;
    logic    phase_reg,  phase_next;
    logic    load;
    logic    take_body;
    result_t body_res, sum_res;

    assign m_tvalid  = tvalid_reg;
    assign m_tuser   = tuser_reg;
    assign m_tdata   = res_reg;
    assign load      = !tvalid_reg || m_tready;
    assign take_body = pop_entry.body_valid && !phase_reg;
    assign pop_ready = load && !(take_body && pop_entry.sum_valid);

    always_comb begin
        body_res             = '0;
        body_res.body_byte   = pop_entry.body_byte;
        body_res.body_offset = pop_entry.body_offset;

        sum_res                 = '0;
        sum_res.status          = pop_entry.status;
        sum_res.kind_seen       = pop_entry.marks[0];
        sum_res.kind_value      = pop_entry.kind_value;
        sum_res.seq_seen        = pop_entry.marks[1];
        sum_res.sequence_number = pop_entry.sequence_number;
        sum_res.flags_seen      = pop_entry.marks[2];
        sum_res.flag_word       = pop_entry.flag_word;
        sum_res.body_seen       = pop_entry.marks[3];
        sum_res.body_length     = pop_entry.body_length;
    end

    always_comb begin
        tvalid_next = tvalid_reg;
        tuser_next  = tuser_reg;
        res_next    = res_reg;
        phase_next  = phase_reg;
        if (load) begin
            tvalid_next = pop_valid;
            if (pop_valid) begin
                if (take_body) begin
                    tuser_next = RES_BODY;
                    res_next   = body_res;
                    phase_next = pop_entry.sum_valid;
                end else begin
                    tuser_next = RES_SUMMARY;
                    res_next   = sum_res;
                    phase_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
            phase_reg  <= 1'b0;
        end else begin
            tvalid_reg <= tvalid_next;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        tuser_reg <= tuser_next;
        res_reg   <= res_next;
    end

endmodule

// File: design/trp_checker.sv
// ----------------------------------------------------------------------------
// trp_checker
// Port-level checks for the TLV record parser, bound to the top level.
// ----------------------------------------------------------------------------
module trp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [trp_pkg::TDATA_W-1:0]   m_tdata,
    input logic                          m_tuser
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_body_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[103:24] == '0)
        else $error("body result carries summary fields");

    a_summary_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[23:0] == '0 && m_tdata[25:24] != 2'd3
            && m_tdata[103:102] == 2'b00)
        else $error("summary result malformed");

endmodule

bind tlv_record_parser trp_checker u_checker (.*);
